FILE: rtl/obb_pkg.sv
// Package for the oriented-box overlap tester: field widths and
// fixed-point constants. No dependencies.
package obb_pkg;
    localparam int FIELD_WIDTH     = 60;
    localparam int COMP_WIDTH_DEF  = 20;
    localparam int POS_FRAC_DEF    = 10;
    localparam int AXIS_FRAC_DEF   = 18;
    localparam int TDATA_WIDTH     = 600;
endpackage

FILE: rtl/obb_obb_overlap_test_core.sv
// Oriented-box overlap tester, separating-axis test over 15 axes.
// Throughput: one box pair per cycle while the output is empty or the result is taken.
// The pipeline stalls as a whole when the result is not taken, so no pair is lost.
// Stages: offset, dot products, split products, product sums, radii, compare, result.
// Reset clears the valid bits only and holds tready low; payload registers are not reset.
// Depends on obb_pkg.
module obb_obb_overlap_test_core #(
    parameter int COMP_WIDTH     = obb_pkg::COMP_WIDTH_DEF,
    parameter int POS_FRAC_BITS  = obb_pkg::POS_FRAC_DEF,
    parameter int AXIS_FRAC_BITS = obb_pkg::AXIS_FRAC_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // a_center, a_axis_u, a_axis_v, a_axis_w, a_half_sizes,
    // b_center, b_axis_u, b_axis_v, b_axis_w, b_half_sizes (60 bits each)
    input  logic [obb_pkg::TDATA_WIDTH-1:0] s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // boxes_overlap, 7 zero bits
    output logic [7:0]                      m_axis_tdata
);
    import obb_pkg::*;

    localparam int W  = COMP_WIDTH;
    localparam int TW = W + 1;
    localparam int PW = 2 * W + 3;
    localparam int LB = (PW + 1) / 2;
    localparam int KW = LB + 1;
    localparam int QW = 2 * KW;
    localparam int SW = 160;
    localparam int PS = POS_FRAC_BITS * 0;

    typedef logic signed [W-1:0]  t_c;
    typedef logic signed [TW-1:0] t_t;
    typedef logic signed [PW-1:0] t_p;
    typedef logic signed [KW-1:0] t_k;
    typedef logic signed [QW-1:0] t_q;
    typedef logic signed [SW-1:0] t_s;

    logic [6:0] r_vld;
    logic       adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv && i_rst_n;

    function automatic t_c comp(input logic [FIELD_WIDTH-1:0] f, input int k);
        logic [FIELD_WIDTH+W-1:0] fx;
        fx = {{W{1'b0}}, f};
        comp = t_c'(fx[k*W +: W]);
    endfunction

    // stage 1: unpack and offset
    t_c r_ax[3][3], r_bx[3][3], r_ha[3], r_hb[3];
    t_t r_t[3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                r_t[c]  <= t_t'(comp(s_axis_tdata[5*FIELD_WIDTH +: FIELD_WIDTH], c))
                         - t_t'(comp(s_axis_tdata[0 +: FIELD_WIDTH], c));
                r_ha[c] <= comp(s_axis_tdata[4*FIELD_WIDTH +: FIELD_WIDTH], c);
                r_hb[c] <= comp(s_axis_tdata[9*FIELD_WIDTH +: FIELD_WIDTH], c);
                for (int i = 0; i < 3; i++) begin
                    r_ax[i][c] <= comp(s_axis_tdata[(1+i)*FIELD_WIDTH +: FIELD_WIDTH], c);
                    r_bx[i][c] <= comp(s_axis_tdata[(6+i)*FIELD_WIDTH +: FIELD_WIDTH], c);
                end
            end
        end
    end

    // stage 2: projections of offset and rotation matrix
    t_p r_ta[3], r_tb[3], r_r[3][3];
    t_c r2_ha[3], r2_hb[3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_ta[i] <= t_p'(r_ax[i][0] * r_t[0]) + t_p'(r_ax[i][1] * r_t[1])
                         + t_p'(r_ax[i][2] * r_t[2]);
                r_tb[i] <= t_p'(r_bx[i][0] * r_t[0]) + t_p'(r_bx[i][1] * r_t[1])
                         + t_p'(r_bx[i][2] * r_t[2]);
                for (int j = 0; j < 3; j++)
                    r_r[i][j] <= t_p'(r_ax[i][0] * r_bx[j][0]) + t_p'(r_ax[i][1] * r_bx[j][1])
                               + t_p'(r_ax[i][2] * r_bx[j][2]);
            end
            r2_ha <= r_ha;
            r2_hb <= r_hb;
        end
    end

    function automatic t_k lo_of(input t_p v);
        lo_of = t_k'({1'b0, v[LB-1:0]});
    endfunction
    function automatic t_k hi_of(input t_p v);
        hi_of = t_k'($signed(v[PW-1:LB]));
    endfunction
    function automatic t_q mul(input t_k a, input t_k b);
        mul = t_q'(a * b);
    endfunction
    function automatic t_q hpart(input t_c h, input t_p v, input int k);
        hpart = mul(t_k'(h), (k == 0) ? hi_of(v) : lo_of(v));
    endfunction
    function automatic t_q tpart(input t_p a, input t_p v, input int k);
        tpart = mul((k < 2) ? hi_of(a) : lo_of(a),
                    (k == 0 || k == 2) ? hi_of(v) : lo_of(v));
    endfunction

    // stage 3: split partial products of half lengths and projections with R
    t_q r_qfa[3][3][2], r_qfb[3][3][2], r_qa1[3][3][2], r_qa2[3][3][2];
    t_q r_qb1[3][3][2], r_qb2[3][3][2], r_qt1[3][3][4], r_qt2[3][3][4];
    t_p r3_ta[3], r3_tb[3];
    t_c r3_ha[3], r3_hb[3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 2; k++) begin
                        r_qfa[i][j][k] <= hpart(r2_ha[i], r_r[i][j], k);
                        r_qfb[i][j][k] <= hpart(r2_hb[j], r_r[i][j], k);
                        r_qa1[i][j][k] <= hpart(r2_ha[(i+1)%3], r_r[(i+2)%3][j], k);
                        r_qa2[i][j][k] <= hpart(r2_ha[(i+2)%3], r_r[(i+1)%3][j], k);
                        r_qb1[i][j][k] <= hpart(r2_hb[(j+1)%3], r_r[i][(j+2)%3], k);
                        r_qb2[i][j][k] <= hpart(r2_hb[(j+2)%3], r_r[i][(j+1)%3], k);
                    end
                    for (int k = 0; k < 4; k++) begin
                        r_qt1[i][j][k] <= tpart(r_ta[(i+2)%3], r_r[(i+1)%3][j], k);
                        r_qt2[i][j][k] <= tpart(r_ta[(i+1)%3], r_r[(i+2)%3][j], k);
                    end
                end
            r3_ta <= r_ta;
            r3_tb <= r_tb;
            r3_ha <= r2_ha;
            r3_hb <= r2_hb;
        end
    end

    function automatic t_s sabs(input t_s v);
        sabs = (v < 0) ? -v : v;
    endfunction
    function automatic t_s hjoin(input t_q p [2]);
        hjoin = (t_s'(p[0]) <<< LB) + t_s'(p[1]);
    endfunction
    function automatic t_s tjoin(input t_q p [4]);
        tjoin = (t_s'(p[0]) <<< (2*LB)) + ((t_s'(p[1]) + t_s'(p[2])) <<< LB) + t_s'(p[3]);
    endfunction

    // stage 4: join partial products; radius terms as magnitudes
    t_s r_fa[3][3], r_fb[3][3], r_ea1[3][3], r_ea2[3][3];
    t_s r_eb1[3][3], r_eb2[3][3], r_et1[3][3], r_et2[3][3];
    t_p r4_ta[3], r4_tb[3];
    t_c r4_ha[3], r4_hb[3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    r_fa[i][j]  <= sabs(hjoin(r_qfa[i][j]));
                    r_fb[i][j]  <= sabs(hjoin(r_qfb[i][j]));
                    r_ea1[i][j] <= sabs(hjoin(r_qa1[i][j]));
                    r_ea2[i][j] <= sabs(hjoin(r_qa2[i][j]));
                    r_eb1[i][j] <= sabs(hjoin(r_qb1[i][j]));
                    r_eb2[i][j] <= sabs(hjoin(r_qb2[i][j]));
                    r_et1[i][j] <= tjoin(r_qt1[i][j]);
                    r_et2[i][j] <= tjoin(r_qt2[i][j]);
                end
            r4_ta <= r3_ta;
            r4_tb <= r3_tb;
            r4_ha <= r3_ha;
            r4_hb <= r3_hb;
        end
    end

    // stage 5: distances and radii; radius terms at scale 2*AXIS, shifted once
    t_s r_d[15], r_rad[15];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_d[i]   <= ((r4_ta[i] < 0) ? -t_s'(r4_ta[i]) : t_s'(r4_ta[i]))
                            <<< (2*AXIS_FRAC_BITS + PS);
                r_rad[i] <= (t_s'(r4_ha[i]) <<< (3*AXIS_FRAC_BITS))
                          + ((r_fb[i][0] + r_fb[i][1] + r_fb[i][2]) <<< AXIS_FRAC_BITS);
                r_d[3+i]   <= ((r4_tb[i] < 0) ? -t_s'(r4_tb[i]) : t_s'(r4_tb[i]))
                              <<< (2*AXIS_FRAC_BITS);
                r_rad[3+i] <= (t_s'(r4_hb[i]) <<< (3*AXIS_FRAC_BITS))
                            + ((r_fa[0][i] + r_fa[1][i] + r_fa[2][i]) <<< AXIS_FRAC_BITS);
            end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    r_d[6+3*i+j]   <= sabs(r_et1[i][j] - r_et2[i][j]);
                    r_rad[6+3*i+j] <= (r_ea1[i][j] + r_ea2[i][j] + r_eb1[i][j] + r_eb2[i][j])
                                      <<< AXIS_FRAC_BITS;
                end
        end
    end

    // stage 6: compare per axis
    logic [14:0] r_sep;
    always_ff @(posedge i_clk) begin
        if (adv)
            for (int k = 0; k < 15; k++)
                r_sep[k] <= r_d[k] > r_rad[k];
    end

    // stage 7: result register
    logic r_ovl;
    always_ff @(posedge i_clk) begin
        if (adv)
            r_ovl <= ~|r_sep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[5:0], s_axis_tvalid};
        end
    end

    assign m_axis_tvalid = r_vld[6];
    assign m_axis_tdata  = {7'd0, r_ovl};
endmodule

FILE: tb/sv/tb_obb_obb_overlap_test_core.sv
// Testbench for obb_obb_overlap_test_core: streams box pairs, predicts the
// overlap bit with an exact separating-axis model and checks every result.
// Depends on obb_pkg and the core.
`timescale 1ns / 1ps

class overlap_scoreboard;
    bit   pending_q[$];
    int   fail_count;

    function void note_pair(bit overlap);
        pending_q = {pending_q, overlap};
    endfunction

    function void check_result(bit got);
        bit want;
        if (pending_q.size() == 0) begin
            $error("boxes_overlap: unexpected result %0d", got);
            fail_count++;
        end else begin
            want = pending_q.pop_front();
            if (want !== got) begin
                $error("boxes_overlap: expected %0d, actual %0d", want, got);
                fail_count++;
            end
        end
    endfunction
endclass

module tb_obb_obb_overlap_test_core;
    localparam int W  = obb_pkg::COMP_WIDTH_DEF;
    localparam int AF = obb_pkg::AXIS_FRAC_DEF;
    localparam int FW = obb_pkg::FIELD_WIDTH;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [127:0] wide_t;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [obb_pkg::TDATA_WIDTH-1:0] s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [7:0]                      m_axis_tdata;

    overlap_scoreboard sb = new();
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    longint cycle_count = 0;

    obb_obb_overlap_test_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint comp(logic [FW-1:0] f, int k);
        logic signed [W-1:0] c;
        c = f[k*W +: W];
        return longint'(c);
    endfunction

    function automatic wide_t rad_term(longint h, longint r);
        wide_t p;
        p = wide_t'(h) * wide_t'(r);
        if (p < 0) p = -p;
        return p <<< AF;
    endfunction

    function automatic bit predict_overlap(logic [obb_pkg::TDATA_WIDTH-1:0] d);
        longint ac[3], bc[3], ha[3], hb[3], t[3], ta[3], tb[3];
        longint ax[3][3], bx[3][3], r[3][3];
        wide_t proj, rad;
        int i1, i2, j1, j2;
        bit sep;
        sep = 1'b0;
        for (int c = 0; c < 3; c++) begin
            ac[c] = comp(d[0*FW +: FW], c);
            ha[c] = comp(d[4*FW +: FW], c);
            bc[c] = comp(d[5*FW +: FW], c);
            hb[c] = comp(d[9*FW +: FW], c);
            t[c] = bc[c] - ac[c];
            for (int i = 0; i < 3; i++) begin
                ax[i][c] = comp(d[(1+i)*FW +: FW], c);
                bx[i][c] = comp(d[(6+i)*FW +: FW], c);
            end
        end
        for (int i = 0; i < 3; i++) begin
            ta[i] = 0;
            tb[i] = 0;
            for (int c = 0; c < 3; c++) begin
                ta[i] += ax[i][c] * t[c];
                tb[i] += bx[i][c] * t[c];
            end
            for (int j = 0; j < 3; j++) begin
                r[i][j] = 0;
                for (int c = 0; c < 3; c++) r[i][j] += ax[i][c] * bx[j][c];
            end
        end
        for (int i = 0; i < 3; i++) begin
            proj = wide_t'(ta[i]);
            if (proj < 0) proj = -proj;
            proj = proj <<< (2*AF);
            rad = wide_t'(ha[i]) <<< (3*AF);
            for (int j = 0; j < 3; j++) rad += rad_term(hb[j], r[i][j]);
            if (proj > rad) sep = 1'b1;
        end
        for (int j = 0; j < 3; j++) begin
            proj = wide_t'(tb[j]);
            if (proj < 0) proj = -proj;
            proj = proj <<< (2*AF);
            rad = wide_t'(hb[j]) <<< (3*AF);
            for (int i = 0; i < 3; i++) rad += rad_term(ha[i], r[i][j]);
            if (proj > rad) sep = 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3; j++) begin
                j1 = (j + 1) % 3;
                j2 = (j + 2) % 3;
                proj = wide_t'(ta[i2]) * wide_t'(r[i1][j])
                     - wide_t'(ta[i1]) * wide_t'(r[i2][j]);
                if (proj < 0) proj = -proj;
                rad = rad_term(ha[i1], r[i2][j]) + rad_term(ha[i2], r[i1][j])
                    + rad_term(hb[j1], r[i][j2]) + rad_term(hb[j2], r[i][j1]);
                if (proj > rad) sep = 1'b1;
            end
        end
        return !sep;
    endfunction

    function automatic logic [FW-1:0] pack3(longint x, longint y, longint z);
        logic [FW-1:0] f;
        f = FW'({$urandom, $urandom});
        f[0 +: W] = x[W-1:0];
        f[W +: W] = y[W-1:0];
        f[2*W +: W] = z[W-1:0];
        return f;
    endfunction

    function automatic logic [FW-1:0] rand_field();
        return FW'({$urandom, $urandom});
    endfunction

    function automatic longint small_val(int span);
        return longint'($urandom_range(2*span)) - span;
    endfunction

    // Rough boxes near each other so both outcomes show up often.
    function automatic logic [obb_pkg::TDATA_WIDTH-1:0] near_pair();
        logic [obb_pkg::TDATA_WIDTH-1:0] d;
        int one;
        one = 1 << AF;
        for (int k = 0; k < 10; k++) begin
            if (k == 0 || k == 5)
                d[k*FW +: FW] = pack3(small_val(6000), small_val(6000), small_val(6000));
            else if (k == 4 || k == 9)
                d[k*FW +: FW] = pack3($urandom_range(4000), $urandom_range(4000),
                                      $urandom_range(4000));
            else
                d[k*FW +: FW] = pack3(small_val(one), small_val(one), small_val(one));
        end
        if ($urandom_range(9) == 0) d[4*FW +: W] = W'(-longint'($urandom_range(500)));
        return d;
    endfunction

    task automatic idle_cycle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_pair(logic [obb_pkg::TDATA_WIDTH-1:0] d);
        while ($urandom_range(99) < send_idle_pct) idle_cycle();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_pair(predict_overlap(d));
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata[0]);
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [obb_pkg::TDATA_WIDTH-1:0] d;
        int one;
        one = 1 << AF;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        d = '0;
        send_pair(d);
        send_pair('1);
        for (int k = 0; k < 10; k++) d[k*FW +: FW] = '0;
        for (int k = 1; k < 4; k++) d[k*FW +: FW] = pack3(k==1 ? one : 0, k==2 ? one : 0,
                                                           k==3 ? one : 0);
        for (int k = 6; k < 9; k++) d[k*FW +: FW] = pack3(k==6 ? one : 0, k==7 ? one : 0,
                                                           k==8 ? one : 0);
        d[4*FW +: FW] = pack3(1024, 1024, 1024);
        d[9*FW +: FW] = pack3(1024, 1024, 1024);
        d[5*FW +: FW] = pack3(2048, 0, 0);
        send_pair(d);
        d[5*FW +: FW] = pack3(2049, 0, 0);
        send_pair(d);
        d[5*FW +: FW] = pack3(0, -2048, 0);
        send_pair(d);
        d[4*FW +: FW] = pack3(-1024, 1024, 1024);
        d[5*FW +: FW] = pack3(1, 0, 0);
        send_pair(d);
        d[0*FW +: FW] = pack3(-(1 << (W-1)), -(1 << (W-1)), -(1 << (W-1)));
        d[5*FW +: FW] = pack3((1 << (W-1)) - 1, (1 << (W-1)) - 1, (1 << (W-1)) - 1);
        send_pair(d);
        d[4*FW +: FW] = pack3((1 << (W-1)) - 1, (1 << (W-1)) - 1, (1 << (W-1)) - 1);
        d[9*FW +: FW] = d[4*FW +: FW];
        send_pair(d);
        for (int k = 0; k < 10; k++)
            d[k*FW +: FW] = pack3(-(1 << (W-1)), (1 << (W-1)) - 1, -(1 << (W-1)));
        send_pair(d);
        for (int n = 0; n < 10; n++) begin
            d = near_pair();
            d[6*FW +: FW] = pack3(small_val(3*one), small_val(3*one), 0);
            send_pair(d);
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 70 : 6) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 70 : 6) : 0;
            for (int n = 0; n < 220; n++) begin
                if (n == 110) begin
                    while (sb.pending_q.size() != 0) idle_cycle();
                end
                if ($urandom_range(3) == 0) begin
                    for (int k = 0; k < 10; k++) d[k*FW +: FW] = rand_field();
                end else begin
                    d = near_pair();
                end
                if ($urandom_range(29) == 0) d = $urandom_range(1) ? '1 : '0;
                send_pair(d);
                if ($urandom_range(15) == 0) repeat ($urandom_range(8)) idle_cycle();
            end
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (sb.pending_q.size() != 0) idle_cycle();
        s_axis_tvalid <= 1'b0;
        repeat (20) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/obb_pkg.sv
rtl/obb_obb_overlap_test_core.sv
tb/sv/tb_obb_obb_overlap_test_core.sv
